// ===== sv/dipe_pkg.sv =====
// Shared types, constants and functions for the data island packet encoder.
// Depends on nothing; every other file of the block uses it.
`timescale 1ns / 1ps

package dipe_pkg;

	localparam int PIXELS = 32;
	localparam int CNT_W = $clog2(PIXELS);
	localparam logic [7:0] ECC_POLY = 8'h83;

	// Raw packet as it enters the block.
	typedef struct packed {
		logic [23:0]      hdr;
		logic [3:0][55:0] sp;
		logic [1:0]       sync;
		logic             first;
	} raw_pkt_t;

	// Packet with the parity bytes appended (HB3 and SB7 of each subpacket).
	typedef struct packed {
		logic [31:0]      hdr;
		logic [3:0][63:0] sp;
		logic [1:0]       sync;
		logic             first;
	} pkt_t;

	// Three nibbles of one pixel before symbol mapping.
	typedef struct packed {
		logic [3:0] n0;
		logic [3:0] n1;
		logic [3:0] n2;
		logic       last;
	} nib_t;

	// Parity contribution of message bit idx in a message of nbytes bytes.
	// Called with constant arguments only, so it folds away at elaboration.
	function automatic logic [7:0] ecc_col(input int idx, input int nbytes);
		logic [7:0] v;
		v = 8'h00;
		for (int j = 0; j < nbytes; j++) begin
			if (j == idx / 8) begin
				v = v ^ (8'h01 << (idx % 8));
			end
			for (int k = 0; k < 8; k++) begin
				v = v[0] ? ((v >> 1) ^ ECC_POLY) : (v >> 1);
			end
		end
		return v;
	endfunction

	// Header parity: XOR of the columns of the set bits.
	function automatic logic [7:0] ecc_hdr(input logic [23:0] d);
		logic [7:0] v;
		v = 8'h00;
		for (int i = 0; i < 24; i++) begin
			if (d[i]) begin
				v = v ^ ecc_col(i, 3);
			end
		end
		return v;
	endfunction

	// Subpacket parity over seven bytes.
	function automatic logic [7:0] ecc_sub(input logic [55:0] d);
		logic [7:0] v;
		v = 8'h00;
		for (int i = 0; i < 56; i++) begin
			if (d[i]) begin
				v = v ^ ecc_col(i, 7);
			end
		end
		return v;
	endfunction

	// TERC4 code table.
	function automatic logic [9:0] terc4(input logic [3:0] n);
		logic [9:0] s;
		case (n)
			4'h0: s = 10'h29c;
			4'h1: s = 10'h263;
			4'h2: s = 10'h2e4;
			4'h3: s = 10'h2e2;
			4'h4: s = 10'h171;
			4'h5: s = 10'h11e;
			4'h6: s = 10'h18e;
			4'h7: s = 10'h13c;
			4'h8: s = 10'h2cc;
			4'h9: s = 10'h139;
			4'ha: s = 10'h19c;
			4'hb: s = 10'h2c6;
			4'hc: s = 10'h28e;
			4'hd: s = 10'h271;
			4'he: s = 10'h163;
			4'hf: s = 10'h2c3;
			default: s = 10'h29c;
		endcase
		return s;
	endfunction

endpackage

// ===== sv/dipe_ecc.sv =====
// Input register and BCH parity stage of the data island packet encoder.
// Depends on dipe_pkg for the packet types and parity functions.
`timescale 1ns / 1ps

module dipe_ecc (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dipe_pkg::raw_pkt_t in_pkt,
	output logic              pkt_valid,
	input  logic              pkt_ready,
	output dipe_pkg::pkt_t    pkt
);

	logic                v_s1;
	logic                v_s2;
	dipe_pkg::raw_pkt_t  raw_s1;
	dipe_pkg::pkt_t      pkt_s2;
	logic                rdy_s2;

	// Each stage takes a new item when it is empty or its item moves on.
	assign rdy_s2   = !v_s2 || pkt_ready;
	assign in_ready = !v_s1 || rdy_s2;

	// Stage 1 holds the raw packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			raw_s1 <= in_pkt;
		end
	end

	// Stage 2 appends the parity bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			pkt_s2.hdr   <= {dipe_pkg::ecc_hdr(raw_s1.hdr), raw_s1.hdr};
			for (int q = 0; q < 4; q++) begin
				pkt_s2.sp[q] <= {dipe_pkg::ecc_sub(raw_s1.sp[q]), raw_s1.sp[q]};
			end
			pkt_s2.sync  <= raw_s1.sync;
			pkt_s2.first <= raw_s1.first;
		end
	end

	assign pkt_valid = v_s2;
	assign pkt       = pkt_s2;

endmodule

// ===== sv/dipe_serializer.sv =====
// Pixel serializer: shifts one parity-complete packet out as 32 nibble triples.
// Depends on dipe_pkg for the packet and nibble types.
`timescale 1ns / 1ps

module dipe_serializer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pkt_valid,
	output logic           pkt_ready,
	input  dipe_pkg::pkt_t pkt,
	output logic           nib_valid,
	input  logic           nib_ready,
	output dipe_pkg::nib_t nib
);

	logic                       ser_v_q;
	logic [dipe_pkg::CNT_W-1:0] cnt_q;
	logic [31:0]                hdr_q;
	logic [3:0][63:0]           sp_q;
	logic [1:0]                 sync_q;
	logic                       first_q;
	logic                       v_s3;
	dipe_pkg::nib_t             nib_s3;
	logic                       rdy_s3;
	logic                       emit;
	logic                       at_last;
	logic                       load;

	assign rdy_s3    = !v_s3 || nib_ready;
	assign emit      = ser_v_q && rdy_s3;
	assign at_last   = (cnt_q == dipe_pkg::CNT_W'(dipe_pkg::PIXELS - 1));
	assign pkt_ready = !ser_v_q || (emit && at_last);
	assign load      = pkt_valid && pkt_ready;

	// Serializer control: busy flag and pixel counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q <= 1'b0;
			cnt_q   <= '0;
		end else if (load) begin
			ser_v_q <= 1'b1;
			cnt_q   <= '0;
		end else if (emit) begin
			ser_v_q <= !at_last;
			cnt_q   <= cnt_q + 1'b1;
		end
	end

	// Packet shift registers; the current pixel's bits always sit at the bottom.
	always_ff @(posedge clk) begin
		if (load) begin
			hdr_q   <= pkt.hdr;
			sp_q    <= pkt.sp;
			sync_q  <= pkt.sync;
			first_q <= pkt.first;
		end else if (emit) begin
			hdr_q   <= hdr_q >> 1;
			for (int q = 0; q < 4; q++) begin
				sp_q[q] <= sp_q[q] >> 2;
			end
			first_q <= 1'b0;
		end
	end

	// Stage 3 holds the nibbles of one pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= ser_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			nib_s3.n0   <= {!first_q, hdr_q[0], sync_q};
			for (int q = 0; q < 4; q++) begin
				nib_s3.n1[q] <= sp_q[q][0];
				nib_s3.n2[q] <= sp_q[q][1];
			end
			nib_s3.last <= at_last;
		end
	end

	assign nib_valid = v_s3;
	assign nib       = nib_s3;

	// A packet in progress keeps the serializer busy until its last pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !at_last) |=> ser_v_q)
		else $error("serializer went idle in the middle of a packet");

	// A new packet always starts at pixel 0.
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (cnt_q == '0))
		else $error("packet load did not restart the pixel counter");

	// A stalled serializer holds its pixel position.
	assert property (@(posedge clk) disable iff (!arst_n)
		(ser_v_q && !emit) |=> $stable(cnt_q))
		else $error("pixel counter moved during a stall");

endmodule

// ===== sv/dipe_terc4.sv =====
// TERC4 symbol mapping and output register of the data island packet encoder.
// Depends on dipe_pkg for the nibble type and the code table.
`timescale 1ns / 1ps

module dipe_terc4 (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           nib_valid,
	output logic           nib_ready,
	input  dipe_pkg::nib_t nib,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [9:0]     lane0_symbol,
	output logic [9:0]     lane1_symbol,
	output logic [9:0]     lane2_symbol,
	output logic           last_pixel
);

	logic       v_s4;
	logic [9:0] l0_s4;
	logic [9:0] l1_s4;
	logic [9:0] l2_s4;
	logic       last_s4;

	assign nib_ready = !v_s4 || out_ready;

	// Stage 4 is the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (nib_ready) begin
			v_s4 <= nib_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (nib_ready && nib_valid) begin
			l0_s4   <= dipe_pkg::terc4(nib.n0);
			l1_s4   <= dipe_pkg::terc4(nib.n1);
			l2_s4   <= dipe_pkg::terc4(nib.n2);
			last_s4 <= nib.last;
		end
	end

	assign out_valid    = v_s4;
	assign lane0_symbol = l0_s4;
	assign lane1_symbol = l1_s4;
	assign lane2_symbol = l2_s4;
	assign last_pixel   = last_s4;

endmodule

// ===== sv/data_island_packet_encoder.sv =====
// Data island packet encoder: takes one packet per item and sends out 32 pixels,
// each a triple of TERC4 symbols, with BCH parity bytes appended to the header
// and to each subpacket. A packet is taken in, its parity is computed in the
// next stage, and a shift-register serializer then produces one pixel per cycle
// while the output is not stalled, so the serializer sets the rate of a steady stream.
// The next packet is accepted and held while the current one is still going
// out, so pixels of consecutive packets follow with no gap. A packet moves
// through the input register, the parity register, the serializer, the nibble
// register and the output register; last_pixel marks pixel 31.
// Depends on dipe_pkg, dipe_ecc, dipe_serializer and dipe_terc4.
`timescale 1ns / 1ps

module data_island_packet_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] header_bytes,
	input  logic [55:0] subpacket_zero,
	input  logic [55:0] subpacket_one,
	input  logic [55:0] subpacket_two,
	input  logic [55:0] subpacket_three,
	input  logic [1:0]  sync_bits,
	input  logic        island_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  lane0_symbol,
	output logic [9:0]  lane1_symbol,
	output logic [9:0]  lane2_symbol,
	output logic        last_pixel
);

	dipe_pkg::raw_pkt_t in_pkt;
	dipe_pkg::pkt_t     pkt;
	dipe_pkg::nib_t     nib;
	logic               pkt_valid;
	logic               pkt_ready;
	logic               nib_valid;
	logic               nib_ready;

	// Gather the input fields into one packet.
	assign in_pkt.hdr   = header_bytes;
	assign in_pkt.sp[0] = subpacket_zero;
	assign in_pkt.sp[1] = subpacket_one;
	assign in_pkt.sp[2] = subpacket_two;
	assign in_pkt.sp[3] = subpacket_three;
	assign in_pkt.sync  = sync_bits;
	assign in_pkt.first = island_start;

	dipe_ecc u_ecc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_pkt    (in_pkt),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt)
	);

	dipe_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt),
		.nib_valid (nib_valid),
		.nib_ready (nib_ready),
		.nib       (nib)
	);

	dipe_terc4 u_terc4 (
		.clk          (clk),
		.arst_n       (arst_n),
		.nib_valid    (nib_valid),
		.nib_ready    (nib_ready),
		.nib          (nib),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.lane0_symbol (lane0_symbol),
		.lane1_symbol (lane1_symbol),
		.lane2_symbol (lane2_symbol),
		.last_pixel   (last_pixel)
	);

endmodule

// ===== verif/data_island_packet_encoder_tb.sv =====
// Self-checking testbench for data_island_packet_encoder: packets go in, their 32 pixels
// are predicted and each output pixel is compared as it is accepted.
// Depends on dipe_pkg and the data_island_packet_encoder RTL.
`timescale 1ns / 1ps

module data_island_packet_encoder_tb;

	localparam int PIXELS_PER_PACKET = 32;
	localparam int RANDOM_PER_PHASE  = 110;
	localparam int LONG_HOLD_CYCLES  = 400;

	// TERC4 code words, indexed by nibble.
	localparam logic [9:0] TERC4_WORD [16] = '{
		10'h29c, 10'h263, 10'h2e4, 10'h2e2,
		10'h171, 10'h11e, 10'h18e, 10'h13c,
		10'h2cc, 10'h139, 10'h19c, 10'h2c6,
		10'h28e, 10'h271, 10'h163, 10'h2c3
	};

	typedef struct {
		logic [9:0] lane0;
		logic [9:0] lane1;
		logic [9:0] lane2;
		logic       last;
	} pixel_t;

	// Keeps the pixels that accepted packets must still produce, oldest first.
	class pixel_scoreboard;
		pixel_t expected_pixels[$];
		int     mismatches = 0;

		// LSB-first CRC-8 over the low nbytes bytes, zero start value.
		function logic [7:0] bch_parity(logic [55:0] msg, int nbytes);
			logic [7:0] crc;
			crc = 8'h00;
			for (int i = 0; i < nbytes; i++) begin
				crc = crc ^ msg[8*i +: 8];
				for (int k = 0; k < 8; k++) begin
					crc = crc[0] ? ((crc >> 1) ^ 8'h83) : (crc >> 1);
				end
			end
			return crc;
		endfunction

		// Works out all 32 pixels of one accepted packet.
		function void note_packet(dipe_pkg::raw_pkt_t pkt);
			logic [31:0]      hdr_full;
			logic [3:0][63:0] sub_full;
			logic [3:0]       nib0, nib1, nib2;
			pixel_t           px;
			hdr_full = {bch_parity({32'h0, pkt.hdr}, 3), pkt.hdr};
			for (int q = 0; q < 4; q++) begin
				sub_full[q] = {bch_parity(pkt.sp[q], 7), pkt.sp[q]};
			end
			for (int p = 0; p < PIXELS_PER_PACKET; p++) begin
				nib0 = {!(pkt.first && p == 0), hdr_full[p], pkt.sync};
				for (int q = 0; q < 4; q++) begin
					nib1[q] = sub_full[q][2*p];
					nib2[q] = sub_full[q][2*p+1];
				end
				px.lane0 = TERC4_WORD[nib0];
				px.lane1 = TERC4_WORD[nib1];
				px.lane2 = TERC4_WORD[nib2];
				px.last  = (p == PIXELS_PER_PACKET - 1);
				expected_pixels.push_back(px);
			end
		endfunction

		function void flag(string field, logic [9:0] want, logic [9:0] got);
			mismatches++;
			$error("%s: expected 'h%0h, got 'h%0h", field, want, got);
		endfunction

		// Compares one output pixel with the oldest expectation.
		function void check_pixel(logic [9:0] l0, logic [9:0] l1, logic [9:0] l2,
				logic last);
			pixel_t want;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				$error("unexpected pixel: lane0 'h%0h lane1 'h%0h lane2 'h%0h",
					l0, l1, l2);
				return;
			end
			want = expected_pixels.pop_front();
			if (l0 !== want.lane0) flag("lane0_symbol", want.lane0, l0);
			if (l1 !== want.lane1) flag("lane1_symbol", want.lane1, l1);
			if (l2 !== want.lane2) flag("lane2_symbol", want.lane2, l2);
			if (last !== want.last) flag("last_pixel", 10'(want.last), 10'(last));
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [23:0] header_bytes = '0;
	logic [55:0] subpacket_zero = '0;
	logic [55:0] subpacket_one = '0;
	logic [55:0] subpacket_two = '0;
	logic [55:0] subpacket_three = '0;
	logic [1:0]  sync_bits = '0;
	logic        island_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [9:0]  lane0_symbol;
	logic [9:0]  lane1_symbol;
	logic [9:0]  lane2_symbol;
	logic        last_pixel;

	pixel_scoreboard sb = new;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_pending = 1'b0;

	data_island_packet_encoder dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.header_bytes    (header_bytes),
		.subpacket_zero  (subpacket_zero),
		.subpacket_one   (subpacket_one),
		.subpacket_two   (subpacket_two),
		.subpacket_three (subpacket_three),
		.sync_bits       (sync_bits),
		.island_start    (island_start),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.lane0_symbol    (lane0_symbol),
		.lane1_symbol    (lane1_symbol),
		.lane2_symbol    (lane2_symbol),
		.last_pixel      (last_pixel)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Output side: random stalls, plus one long hold-off when requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				hold_pending = 1'b0;
			end
			out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Every accepted pixel is checked against the prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_pixel(lane0_symbol, lane1_symbol, lane2_symbol, last_pixel);
		end
	end

	// Offers one packet, with random idle cycles first, and waits until it is taken.
	task automatic send_packet(input dipe_pkg::raw_pkt_t pkt);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			header_bytes <= 24'($urandom);
			sync_bits <= 2'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		header_bytes <= pkt.hdr;
		subpacket_zero <= pkt.sp[0];
		subpacket_one <= pkt.sp[1];
		subpacket_two <= pkt.sp[2];
		subpacket_three <= pkt.sp[3];
		sync_bits <= pkt.sync;
		island_start <= pkt.first;
		do @(posedge clk); while (!in_ready);
		sb.note_packet(pkt);
	endtask

	// Random subpacket bytes, now and then a corner value.
	function automatic logic [55:0] rand_subpacket();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 56'h1 << $urandom_range(55);
			default: return 56'({$urandom, $urandom});
		endcase
	endfunction

	function automatic dipe_pkg::raw_pkt_t rand_packet();
		dipe_pkg::raw_pkt_t pkt;
		pkt.hdr = ($urandom_range(9) == 0) ? 24'h1 << $urandom_range(23) : 24'($urandom);
		for (int q = 0; q < 4; q++) begin
			pkt.sp[q] = rand_subpacket();
		end
		pkt.sync = 2'($urandom);
		pkt.first = ($urandom_range(3) == 0);
		return pkt;
	endfunction

	// Short directed set: extremes, single bits for parity, first packet with every sync.
	task automatic run_directed();
		dipe_pkg::raw_pkt_t pkt;
		pkt = '0;
		send_packet(pkt);
		pkt = '1;
		send_packet(pkt);
		for (int s = 0; s < 4; s++) begin
			pkt = '0;
			pkt.sync = 2'(s);
			pkt.first = 1'b1;
			pkt.hdr = 24'h000001 << (s * 7);
			send_packet(pkt);
		end
		pkt = '1;
		pkt.first = 1'b0;
		send_packet(pkt);
		pkt = '0;
		pkt.hdr = 24'h800000;
		pkt.sp[0] = 56'h1;
		pkt.sp[1] = 56'h80_0000_0000_0000;
		pkt.sp[2] = 56'h55_5555_5555_5555;
		pkt.sp[3] = 56'haa_aaaa_aaaa_aaaa;
		send_packet(pkt);
		pkt.hdr = 24'ha5a5a5;
		pkt.sp[0] = 56'hff;
		pkt.sp[1] = 56'hff_0000_0000_0000;
		pkt.sp[2] = 56'h12_3456_789a_bcde;
		pkt.sp[3] = 56'hfe_dcba_9876_5432;
		pkt.sync = 2'b10;
		send_packet(pkt);
		pkt.first = 1'b1;
		pkt.hdr = 24'h5a5a5a;
		send_packet(pkt);
		for (int b = 0; b < 4; b++) begin
			pkt = '0;
			pkt.sp[b] = '1;
			pkt.hdr = 24'hff << (8 * (b % 3));
			pkt.sync = 2'(b);
			send_packet(pkt);
		end
	endtask

	// Main sequence: reset, directed packets, then random packets in idling phases.
	initial begin
		int drain_cycles;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					hold_pending = 1'b1;
				end
				1: begin
					send_idle_pct = 65;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 65;
				end
				default: begin
					send_idle_pct = 37;
					recv_stall_pct = 37;
				end
			endcase
			repeat (RANDOM_PER_PHASE) send_packet(rand_packet());
		end
		in_valid <= 1'b0;
		recv_stall_pct = 0;

		drain_cycles = 0;
		while (sb.pending() != 0 && drain_cycles < 20000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (64) @(posedge clk);

		if (sb.pending() == 0 && sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			if (sb.pending() != 0) begin
				$error("%0d expected pixels never arrived", sb.pending());
			end
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
